### rtl/core/smsi_pkg.sv
`default_nettype none
package smsi_pkg;
   localparam int SMSI_DATA_WIDTH = 64;
   localparam int FIELD_WIDTH     = 64;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_OVF   = 2'd2
   } status_type;

   typedef enum logic {
      REG_BASE  = 1'b0,
      REG_LIMIT = 1'b1
   } reg_index_type;
endpackage
`default_nettype wire

### rtl/core/smsi_if.sv
`default_nettype none
interface smsi_req_if import smsi_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [FIELD_WIDTH-1:0] index;
   modport source (output valid, output index, input ready);
   modport sink   (input valid, input index, output ready);
endinterface

interface smsi_rsp_if import smsi_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [FIELD_WIDTH-1:0] value;
   logic [1:0]             status;
   modport source (output valid, output value, output status, input ready);
   modport sink   (input valid, input value, input status, output ready);
endinterface
`default_nettype wire

### rtl/core/smsi_div.sv
`default_nettype none
module smsi_div import smsi_pkg::*; #(
   parameter int DATA_WIDTH = SMSI_DATA_WIDTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  en,
   input  wire logic                  valid_in,
   input  wire logic [DATA_WIDTH-1:0] idx_in,
   input  wire logic                  oor_in,
   input  wire logic [DATA_WIDTH-1:0] divisor,
   output logic                       valid_out,
   output logic [DATA_WIDTH-1:0]      idx_out,
   output logic [DATA_WIDTH-1:0]      quot_out,
   output logic                       oor_out
);
   localparam int W = DATA_WIDTH;

   logic [W-1:0] rem_ff  [W+1];
   logic [W-1:0] work_ff [W+1];
   logic [W-1:0] idx_ff  [W+1];
   logic         oor_ff  [W+1];
   logic         vld_ff  [W+1];

   // stage zero is the entering request itself
   assign rem_ff[0]  = '0;
   assign work_ff[0] = idx_in;
   assign idx_ff[0]  = idx_in;
   assign oor_ff[0]  = oor_in;
   assign vld_ff[0]  = valid_in;

   for (genvar i = 0; i < W; i++) begin : g_step
      logic [W:0]   trial;
      logic         ge;
      logic [W:0]   diff;
      logic [W-1:0] rem_in;
      logic [W-1:0] work_in;

      always_comb begin
         trial   = {rem_ff[i], work_ff[i][W-1]};
         ge      = trial >= {1'b0, divisor};
         diff    = trial - {1'b0, divisor};
         rem_in  = ge ? diff[W-1:0] : trial[W-1:0];
         work_in = {work_ff[i][W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else if (en) begin
            vld_ff[i+1] <= vld_ff[i];
         end
         if (en) begin
            rem_ff[i+1]  <= rem_in;
            work_ff[i+1] <= work_in;
            idx_ff[i+1]  <= idx_ff[i];
            oor_ff[i+1]  <= oor_ff[i];
         end
      end
   end

   assign valid_out = vld_ff[W];
   assign idx_out   = idx_ff[W];
   assign quot_out  = work_ff[W];
   assign oor_out   = oor_ff[W];
endmodule
`default_nettype wire

### rtl/core/smsi_mul.sv
`default_nettype none
module smsi_mul import smsi_pkg::*; #(
   parameter int DATA_WIDTH = SMSI_DATA_WIDTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  en,
   input  wire logic                  valid_in,
   input  wire logic [DATA_WIDTH-1:0] base,
   input  wire logic [DATA_WIDTH-1:0] inner,
   input  wire logic                  oor_in,
   input  wire logic                  ovf_in,
   output logic                       valid_out,
   output logic [DATA_WIDTH-1:0]      value_out,
   output status_type                 status_out
);
   localparam int W  = DATA_WIDTH;
   localparam int H  = (W + 1) / 2;
   localparam int HW = W - H;

   logic [H-1:0]  nl, il;
   logic [HW-1:0] nh, ih;
   assign nl = base[H-1:0];
   assign nh = base[W-1:H];
   assign il = inner[H-1:0];
   assign ih = inner[W-1:H];

   logic [2*H-1:0]  ll_ff;
   logic [W-1:0]    hl_ff, lh_ff;
   logic            hh_ff, oor_a_ff, ovf_a_ff, vld_a_ff;

   // split product: the high-by-high term only matters as non-zero
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
      end else if (en) begin
         vld_a_ff <= valid_in;
      end
      if (en) begin
         ll_ff    <= nl * il;
         hl_ff    <= nh * il;
         lh_ff    <= nl * ih;
         hh_ff    <= (|nh) && (|ih);
         oor_a_ff <= oor_in;
         ovf_a_ff <= ovf_in;
      end
   end

   logic [2*W+1:0] mid;
   logic [2*W+1:0] total;
   logic           ovf2;
   logic [W-1:0]   value_in;
   status_type     status_in;

   always_comb begin
      mid   = (2*W+2)'(hl_ff) + (2*W+2)'(lh_ff);
      total = (2*W+2)'(ll_ff) + (mid << H);
      ovf2  = hh_ff || (|total[2*W+1:W]);
      if (oor_a_ff) begin
         status_in = ST_RANGE;
      end else if (ovf_a_ff || ovf2) begin
         status_in = ST_OVF;
      end else begin
         status_in = ST_OK;
      end
      value_in = (status_in == ST_OK) ? total[W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_out <= 1'b0;
      end else if (en) begin
         valid_out <= vld_a_ff;
      end
      if (en) begin
         value_out  <= value_in;
         status_out <= status_in;
      end
   end
endmodule
`default_nettype wire

### rtl/core/single_multiple_sequence_index.sv
// Single-multiple sequence indexer.
// A request on req_chan carries an index; the response on rsp_chan carries
// element "index" of the ascending multiples of base that base squared does
// not divide, with status ok, index out of range, or overflow (value zero
// unless ok). Both channels hand over a request when valid and ready are high.
// Configuration: csr_we with csr_index selecting base or index_limit and
// csr_wdata; small writes clamp (base to 2, limit to 1). Write only when idle.
// Throughput: one request per cycle, sustained while responses are taken.
// Pipeline: one restoring-divider
// stage per quotient bit, one stage for the inner term, two for the split
// multiplier, whose last register is the response register.
// Reset: synchronous, clears every stage valid and sets base 2, limit 1.
// Stall: when the response is held the whole pipeline freezes and req ready
// drops; nothing is lost or repeated, and bubbles travel down the pipeline
// with the requests whenever the output is empty or taken.
`default_nettype none
module single_multiple_sequence_index import smsi_pkg::*; #(
   parameter int DATA_WIDTH = SMSI_DATA_WIDTH
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   smsi_req_if.sink                    req_chan,
   smsi_rsp_if.source                  rsp_chan,
   input  wire logic                   csr_we,
   input  wire logic                   csr_index,
   input  wire logic [FIELD_WIDTH-1:0] csr_wdata
);
   localparam int W = DATA_WIDTH;

   logic [W-1:0] base_ff, limit_ff;
   logic [W-1:0] wr_val;
   logic         adv;
   logic         rsp_valid;

   assign wr_val = csr_wdata[W-1:0];

   // hold configuration; clamp small writes
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= W'(2);
         limit_ff <= W'(1);
      end else if (csr_we) begin
         unique case (reg_index_type'(csr_index))
            REG_BASE:  base_ff  <= (wr_val < W'(2)) ? W'(2) : wr_val;
            REG_LIMIT: limit_ff <= (wr_val < W'(1)) ? W'(1) : wr_val;
            default: ;
         endcase
      end
   end

   // advance every stage unless a held response blocks the output
   assign adv            = !rsp_valid || rsp_chan.ready;
   assign req_chan.ready = adv;

   logic [W-1:0] idx;
   logic         oor;
   assign idx = req_chan.index[W-1:0];
   assign oor = idx >= limit_ff;

   logic         d_valid, d_oor;
   logic [W-1:0] d_idx, d_quot;

   smsi_div #(.DATA_WIDTH(W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .valid_in  (req_chan.valid),
      .idx_in    (idx),
      .oor_in    (oor),
      .divisor   (base_ff - W'(1)),
      .valid_out (d_valid),
      .idx_out   (d_idx),
      .quot_out  (d_quot),
      .oor_out   (d_oor)
   );

   // inner = q*n + r + 1 = idx + q + 1
   logic [W+1:0] inner_sum;
   logic [W-1:0] inner_ff;
   logic         ovf_ff, oor_ff, vld_ff;

   assign inner_sum = {2'b00, d_idx} + {2'b00, d_quot} + (W+2)'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= d_valid;
      end
      if (adv) begin
         inner_ff <= inner_sum[W-1:0];
         ovf_ff   <= |inner_sum[W+1:W];
         oor_ff   <= d_oor;
      end
   end

   logic [W-1:0] m_value;
   status_type   m_status;

   smsi_mul #(.DATA_WIDTH(W)) u_mul (
      .clock      (clock),
      .reset      (reset),
      .en         (adv),
      .valid_in   (vld_ff),
      .base       (base_ff),
      .inner      (inner_ff),
      .oor_in     (oor_ff),
      .ovf_in     (ovf_ff),
      .valid_out  (rsp_valid),
      .value_out  (m_value),
      .status_out (m_status)
   );

   assign rsp_chan.valid  = rsp_valid;
   assign rsp_chan.value  = FIELD_WIDTH'(m_value);
   assign rsp_chan.status = m_status;
endmodule
`default_nettype wire

### rtl/core/smsi_check.sv
`default_nettype none
module smsi_check import smsi_pkg::*; (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_ready,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_ready,
   input wire logic [FIELD_WIDTH-1:0] rsp_value,
   input wire logic [1:0]             rsp_status
);
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_stall_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while response held");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_status))
      else $error("held response changed");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_value == '0 && rsp_status != 2'd3)
      else $error("error response with non-zero value");
endmodule

bind single_multiple_sequence_index smsi_check u_check (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_value  (rsp_chan.value),
   .rsp_status (rsp_chan.status)
);
`default_nettype wire

### bench/smsi_bench_if.sv
`timescale 1ns / 100ps
`default_nettype none
// Bus-functional bundles used only by the bench are the RTL interfaces
// themselves; this file holds the bench's own expected-result type.
package smsi_bench_pkg;
   import smsi_pkg::*;

   typedef struct packed {
      logic [FIELD_WIDTH-1:0] value;
      status_type             status;
   } seq_result_type;
endpackage
`default_nettype wire

### bench/smsi_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module smsi_checker import smsi_pkg::*; import smsi_bench_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   smsi_req_if                         req_chan,
   smsi_rsp_if                         rsp_chan,
   input  wire logic                   csr_we,
   input  wire logic                   csr_index,
   input  wire logic [FIELD_WIDTH-1:0] csr_wdata,
   output int                          fail_count,
   output int                          pending_count
);
   logic [63:0]    base_n;
   logic [63:0]    count_limit;
   seq_result_type pending_results[$];

   function automatic seq_result_type element_at(logic [63:0] idx);
      seq_result_type res;
      logic [127:0] q, r, inner, prod;
      res.value  = '0;
      res.status = ST_OK;
      if (idx >= count_limit) begin
         res.status = ST_RANGE;
         return res;
      end
      q = idx / (base_n - 1);
      r = idx % (base_n - 1);
      inner = q * base_n + r + 1;
      if (inner > 128'hFFFF_FFFF_FFFF_FFFF) begin
         res.status = ST_OVF;
         return res;
      end
      prod = inner * base_n;
      if (prod > 128'hFFFF_FFFF_FFFF_FFFF) begin
         res.status = ST_OVF;
         return res;
      end
      res.value = prod[63:0];
      return res;
   endfunction

   assign pending_count = pending_results.size();

   always @(posedge clock) begin
      seq_result_type exp_res;
      int             errs;
      errs = 0;
      if (reset) begin
         base_n      <= 64'd2;
         count_limit <= 64'd1;
         fail_count  <= 0;
         pending_results.delete();
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_results.size() == 0) begin
               $error("unexpected response value=%h status=%0d",
                      rsp_chan.value, rsp_chan.status);
               errs = errs + 1;
            end else begin
               exp_res = pending_results.pop_front();
               if (rsp_chan.value !== exp_res.value) begin
                  $error("value expected %h actual %h", exp_res.value, rsp_chan.value);
                  errs = errs + 1;
               end
               if (rsp_chan.status !== exp_res.status) begin
                  $error("status expected %0d actual %0d", exp_res.status,
                         rsp_chan.status);
                  errs = errs + 1;
               end
            end
         end
         fail_count <= fail_count + errs;
         if (req_chan.valid && req_chan.ready)
            pending_results.push_back(element_at(req_chan.index));
         if (csr_we) begin
            if (csr_index == REG_BASE)
               base_n <= (csr_wdata < 2) ? 64'd2 : csr_wdata;
            else
               count_limit <= (csr_wdata == 0) ? 64'd1 : csr_wdata;
         end
      end
   end
endmodule
`default_nettype wire

### bench/single_multiple_sequence_index_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module single_multiple_sequence_index_tb;
   import smsi_pkg::*;

   localparam int LATENCY = SMSI_DATA_WIDTH + 3;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic                   csr_index;
   logic [FIELD_WIDTH-1:0] csr_wdata;
   int                     fail_count;
   int                     pending_count;
   logic                   hold_off;    // long receiver stall request

   smsi_req_if req_chan ();
   smsi_rsp_if rsp_chan ();

   single_multiple_sequence_index i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   smsi_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_chan),
      .rsp_chan      (rsp_chan),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Limit: generous against ~1150 requests each waiting out stalls.
   initial begin
      #2000000;
      $display("Verification failed");
      $finish;
   end

   // Receiver: stall on its own random pattern, with calm stretches and one
   // long hold-off when asked.
   initial begin
      int mode;
      int span;
      rsp_chan.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off) begin
            rsp_chan.ready <= 1'b0;
            repeat (200) @(posedge clock);
            hold_off = 1'b0;
         end
         mode = $urandom_range(0, 3);
         span = $urandom_range(1, 40);
         repeat (span) begin
            case (mode)
               0: begin
                  rsp_chan.ready <= 1'b1;
               end
               1: begin
                  rsp_chan.ready <= ($urandom_range(0, 3) != 0);
               end
               2: begin
                  rsp_chan.ready <= ($urandom_range(0, 3) == 0);
               end
               default: begin
                  rsp_chan.ready <= $urandom_range(0, 1);
               end
            endcase
            @(posedge clock);
         end
      end
   end

   // Offer one request, holding valid until it is taken.
   task automatic send_request(input logic [63:0] idx);
      req_chan.valid <= 1'b1;
      req_chan.index <= idx;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // Sometimes drop valid for a random gap.
   task automatic idle_gap();
      int gap;
      gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Wait until every expected response has arrived, then let the pipe drain.
   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic write_reg(input reg_index_type which, input logic [63:0] data);
      csr_we    <= 1'b1;
      csr_index <= which;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Random index: mostly below or near the limit, sometimes wide or near all ones.
   function automatic logic [63:0] pick_index(logic [63:0] lim);
      logic [63:0] v;
      case ($urandom_range(0, 5))
         0: v = {$urandom, $urandom};
         1: v = lim - 64'($urandom_range(0, 3));
         2: v = lim + 64'($urandom_range(0, 3));
         3: v = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 3));
         default: v = {$urandom, $urandom} % ((lim == 0) ? 64'd1 : lim);
      endcase
      return v;
   endfunction

   initial begin
      logic [63:0] cur_base;
      logic [63:0] cur_limit;
      int          burst;
      req_chan.valid = 1'b0;
      req_chan.index = '0;
      csr_we         = 1'b0;
      csr_index      = REG_BASE;
      csr_wdata      = '0;
      hold_off       = 1'b0;
      reset          = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset settings, then out of range and overflow cases.
      send_request(64'd0);
      send_request(64'd1);
      send_request(64'hFFFF_FFFF_FFFF_FFFF);
      drain();
      write_reg(REG_BASE, 64'd0);          // clamps to 2
      write_reg(REG_LIMIT, 64'd0);         // clamps to 1
      send_request(64'd0);
      send_request(64'd1);
      drain();
      write_reg(REG_BASE, 64'd1);
      write_reg(REG_LIMIT, 64'hFFFF_FFFF_FFFF_FFFF);
      send_request(64'd0);
      send_request(64'd5);
      send_request(64'h3FFF_FFFF_FFFF_FFFE);
      send_request(64'h4000_0000_0000_0000);
      send_request(64'hFFFF_FFFF_FFFF_FFFE);
      send_request(64'hFFFF_FFFF_FFFF_FFFF);
      drain();
      write_reg(REG_BASE, 64'hFFFF_FFFF_FFFF_FFFF);
      send_request(64'd0);
      send_request(64'd1);
      send_request(64'hFFFF_FFFF_FFFF_FFFD);
      send_request(64'hFFFF_FFFF_FFFF_FFFE);
      drain();
      write_reg(REG_BASE, 64'h0000_0001_0000_0000);
      send_request(64'd0);
      send_request(64'hFFFF_FFFE);
      send_request(64'hFFFF_FFFF);
      send_request(64'h0000_0001_0000_0000);
      drain();
      write_reg(REG_BASE, 64'd3);
      write_reg(REG_LIMIT, 64'd10);
      send_request(64'd9);
      send_request(64'd10);
      send_request(64'd0);

      // Fill the pipe against a long receiver hold-off.
      hold_off = 1'b1;
      repeat (120) send_request(64'($urandom_range(0, 12)));
      // Pause the sender until every response is back.
      drain();

      // Random phases, each with its own register setting.
      repeat (10) begin
         case ($urandom_range(0, 3))
            0: cur_base = 64'($urandom_range(0, 20));
            1: cur_base = {$urandom, $urandom};
            2: cur_base = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 2));
            default: cur_base = 64'd1 << $urandom_range(1, 63);
         endcase
         case ($urandom_range(0, 2))
            0: cur_limit = 64'($urandom_range(0, 100));
            1: cur_limit = {$urandom, $urandom};
            default: cur_limit = 64'hFFFF_FFFF_FFFF_FFFF;
         endcase
         write_reg(REG_BASE, cur_base);
         write_reg(REG_LIMIT, cur_limit);
         burst = 0;
         repeat (100) begin
            send_request(pick_index((cur_limit == 0) ? 64'd1 : cur_limit));
            if (burst == 0) begin
               idle_gap();
               burst = $urandom_range(1, 20);
            end else begin
               burst--;
            end
         end
         drain();
      end

      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
`default_nettype wire
